>>> rtl/dmc_pkg.sv
// Shared constants and types for the division magic constant generator.
package dmc_pkg;

    localparam int DIVISOR_WIDTH = 31;
    localparam int MULT_WIDTH    = 32;
    localparam int SHIFT_WIDTH   = 5;
    localparam int MAX_SHIFT     = 30;
    localparam int STEP_WIDTH    = 5;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

>>> rtl/dmc_if.sv
// Valid/ready channel interfaces for divisor requests and constant responses.
interface dmc_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [dmc_pkg::DIVISOR_WIDTH-1:0]    divisor;

    modport source (output valid, output divisor, input ready);
    modport sink   (input valid, input divisor, output ready);
endinterface

interface dmc_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [dmc_pkg::MULT_WIDTH-1:0]       multiplier;
    logic [dmc_pkg::SHIFT_WIDTH-1:0]      shift_amount;
    logic                                 invalid;

    modport source (output valid, output multiplier, output shift_amount, output invalid,
                    input ready);
    modport sink   (input valid, input multiplier, input shift_amount, input invalid,
                    output ready);
endinterface

>>> rtl/division_magic_constant_gen.sv
// Top level: iterative generator of the multiplier and shift for signed division by a constant.
// An invalid divisor (zero or a power of two) is answered in the cycle after its transfer.
// A valid divisor is answered once the division and the checks have found the shift s
// (0 to 30); one shared subtract-and-compare unit does both the division steps and the checks.
// Throughput: one divisor at a time; the next is taken once the result has been transferred.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle with no result pending.
module division_magic_constant_gen (
    input  logic          clk,
    input  logic          rst_n,
    dmc_req_if.sink       req,
    dmc_rsp_if.source     rsp
);

    // The sequencer runs a restoring long division of 2^32 by d, one quotient bit per
    // cycle, keeping the running remainder r = 2^k mod d and the quotient floor(2^k / d).
    // After the first 32 steps it alternates between a check of the condition
    // 2^(s+1) + r >= d and one further division step, which moves on to the next shift.
    // Both the division step and the check use the same subtractor against d.
    // Only the low 32 quotient bits are kept, as only they reach the multiplier.

    dmc_pkg::state_t                        state_reg, state_next;
    logic [dmc_pkg::DIVISOR_WIDTH-1:0]      d_reg;
    logic [dmc_pkg::DIVISOR_WIDTH-1:0]      rem_reg, rem_next;
    logic [dmc_pkg::MULT_WIDTH-1:0]         quot_reg, quot_next;
    logic [dmc_pkg::STEP_WIDTH-1:0]         step_reg, step_next;
    logic [dmc_pkg::SHIFT_WIDTH-1:0]        shift_reg, shift_next;
    logic [dmc_pkg::MULT_WIDTH-1:0]         pow_reg, pow_next;
    logic [dmc_pkg::MULT_WIDTH-1:0]         mult_reg, mult_next;
    logic [dmc_pkg::SHIFT_WIDTH-1:0]        shout_reg, shout_next;
    logic                                   inval_reg, inval_next;

    logic                                   req_fire;
    logic                                   rsp_fire;
    logic                                   bad_divisor;
    logic [dmc_pkg::MULT_WIDTH-1:0]         sub_a;
    logic [dmc_pkg::MULT_WIDTH:0]           sub_diff;
    logic                                   sub_ge;

    assign req.ready = (state_reg == dmc_pkg::ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp_fire  = rsp.valid && rsp.ready;

    assign bad_divisor = (req.divisor == '0) ||
                         ((req.divisor & (req.divisor - 1'b1)) == '0);

    // Shared subtract-and-compare unit. The doubled remainder fits in 32 bits because
    // r is below d, which is below 2^31; so does 2^(s+1) + r for s up to 30.
    always_comb
    begin
        if (state_reg == dmc_pkg::ST_CHECK)
        begin
            sub_a = pow_reg + {1'b0, rem_reg};
        end
        else
        begin
            sub_a = {rem_reg, 1'b0};
        end
    end

    assign sub_diff = {1'b0, sub_a} - {2'b00, d_reg};
    assign sub_ge   = ~sub_diff[dmc_pkg::MULT_WIDTH];

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        step_next  = step_reg;
        shift_next = shift_reg;
        pow_next   = pow_reg;
        mult_next  = mult_reg;
        shout_next = shout_reg;
        inval_next = inval_reg;

        unique case (state_reg)
            dmc_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    rem_next   = {{(dmc_pkg::DIVISOR_WIDTH-1){1'b0}}, 1'b1};
                    quot_next  = '0;
                    step_next  = '0;
                    shift_next = '0;
                    pow_next   = {{(dmc_pkg::MULT_WIDTH-2){1'b0}}, 2'b10};
                    mult_next  = '0;
                    shout_next = '0;
                    inval_next = bad_divisor;
                    state_next = bad_divisor ? dmc_pkg::ST_DONE : dmc_pkg::ST_DIV;
                end
            end
            dmc_pkg::ST_DIV:
            begin
                rem_next  = sub_ge ? sub_diff[dmc_pkg::DIVISOR_WIDTH-1:0]
                                   : sub_a[dmc_pkg::DIVISOR_WIDTH-1:0];
                quot_next = {quot_reg[dmc_pkg::MULT_WIDTH-2:0], sub_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == '1)
                begin
                    state_next = dmc_pkg::ST_CHECK;
                end
            end
            dmc_pkg::ST_CHECK:
            begin
                if (sub_ge || (shift_reg == dmc_pkg::SHIFT_WIDTH'(dmc_pkg::MAX_SHIFT)))
                begin
                    mult_next  = quot_reg + 1'b1;
                    shout_next = shift_reg;
                    state_next = dmc_pkg::ST_DONE;
                end
                else
                begin
                    // One more quotient bit takes the dividend to the next power of two.
                    shift_next = shift_reg + 1'b1;
                    pow_next   = {pow_reg[dmc_pkg::MULT_WIDTH-2:0], 1'b0};
                    step_next  = '1;
                    state_next = dmc_pkg::ST_DIV;
                end
            end
            dmc_pkg::ST_DONE:
            begin
                if (rsp_fire)
                begin
                    state_next = dmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            d_reg <= req.divisor;
        end
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        step_reg  <= step_next;
        shift_reg <= shift_next;
        pow_reg   <= pow_next;
        mult_reg  <= mult_next;
        shout_reg <= shout_next;
        inval_reg <= inval_next;
    end

    assign rsp.valid        = (state_reg == dmc_pkg::ST_DONE);
    assign rsp.multiplier   = mult_reg;
    assign rsp.shift_amount = shout_reg;
    assign rsp.invalid      = inval_reg;

`ifndef SYNTHESIS
    // An invalid divisor must come back with zero multiplier and shift.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.invalid) |-> (rsp.multiplier == '0 && rsp.shift_amount == '0))
        else $error("invalid result carries a non-zero multiplier or shift");

    // The shift never passes its bound.
    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.shift_amount <= dmc_pkg::SHIFT_WIDTH'(dmc_pkg::MAX_SHIFT)))
        else $error("shift amount above its bound");

    // The running remainder stays below the divisor while the division runs.
    a_rem_below_d: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dmc_pkg::ST_DIV || state_reg == dmc_pkg::ST_CHECK) |-> (rem_reg < d_reg))
        else $error("remainder not reduced below the divisor");

    // A transfer in starts work, so no second divisor is taken in the next cycle.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req.ready)
        else $error("request channel ready while a divisor is in work");
`endif

endmodule
